>>> rtl/cfc_pkg.sv
// Shared types, codes and constants of the fly camera controller.
package cfc_pkg;

    // Input item kinds
    localparam logic [1:0] MODE_POINTER = 2'd0;
    localparam logic [1:0] MODE_KEY     = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_RESET   = 2'd3;

    // Movement keys, also the bit positions of the held flags
    localparam logic [1:0] KEY_FWD   = 2'd0;
    localparam logic [1:0] KEY_LEFT  = 2'd1;
    localparam logic [1:0] KEY_BACK  = 2'd2;
    localparam logic [1:0] KEY_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SENS  = 2'd0;
    localparam logic [1:0] CFG_SPEED = 2'd1;
    localparam logic [1:0] CFG_PLIM  = 2'd2;

    // Divide/root unit operations
    localparam logic DS_DIV  = 1'b0;
    localparam logic DS_SQRT = 1'b1;

    localparam int DIR_FB = 14;

    localparam logic signed [24:0] HEADING_RST = -25'sd5898240;
    localparam logic signed [24:0] HALF_TURN   = 25'sd11796480;
    localparam logic [35:0]        FULL_TURN   = 36'd23592960;
    // 512 full turns: lifts any heading sum above zero before the wrap
    localparam logic [35:0]        WRAP_BIAS   = 36'd12079595520;
    localparam logic signed [23:0] PITCH_BOUND = 24'sd5832704;
    localparam logic [6:0]         PITCH_MAX   = 7'd89;
    localparam logic signed [15:0] DIR_ONE     = 16'sd16384;
    localparam logic signed [31:0] POS_Z_RST   = 32'sd196608;
    localparam logic signed [25:0] QUARTER_ANG = 26'sd5898240;
    localparam logic signed [25:0] HALF_ANG    = 26'sd11796480;
    localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;

    typedef struct packed {
        logic                start;
        logic signed [25:0]  angle;
    } t_cordic_req;

    typedef struct packed {
        logic                done;
        logic signed [15:0]  sin_v;
        logic signed [15:0]  cos_v;
    } t_cordic_rsp;

    typedef struct packed {
        logic         start;
        logic         op;
        logic [31:0]  num;
        logic [15:0]  den;
    } t_ds_req;

    typedef struct packed {
        logic         done;
        logic [31:0]  res;
    } t_ds_rsp;

    // atan(2^-i) in Q.16 degrees
    function automatic logic [22:0] atan_deg(input logic [3:0] idx);
        logic [22:0] v;
        case (idx)
            4'd0:    v = 23'd2949120;
            4'd1:    v = 23'd1740967;
            4'd2:    v = 23'd919879;
            4'd3:    v = 23'd466945;
            4'd4:    v = 23'd234379;
            4'd5:    v = 23'd117304;
            4'd6:    v = 23'd58666;
            4'd7:    v = 23'd29335;
            4'd8:    v = 23'd14668;
            4'd9:    v = 23'd7334;
            4'd10:   v = 23'd3667;
            4'd11:   v = 23'd1833;
            4'd12:   v = 23'd917;
            4'd13:   v = 23'd458;
            4'd14:   v = 23'd229;
            4'd15:   v = 23'd115;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/cfc_if.sv
// Valid/ready channel interfaces for input items and result items.
interface cfc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic [1:0]         key_code;
    logic               key_pressed;
    logic [15:0]        frame_time;

    modport source (output valid, mode, pointer_x, pointer_y, key_code, key_pressed,
                    frame_time, input ready);
    modport sink   (input valid, mode, pointer_x, pointer_y, key_code, key_pressed,
                    frame_time, output ready);
endinterface

interface cfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [24:0] yaw_angle;
    logic signed [23:0] pitch_angle;

    modport source (output valid, dir_x, dir_y, dir_z, pos_x, pos_y, pos_z, yaw_angle,
                    pitch_angle, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, pos_x, pos_y, pos_z, yaw_angle,
                    pitch_angle, output ready);
endinterface

>>> rtl/cfc_cordic.sv
// Iterative 16-step CORDIC giving sine and cosine of an angle in Q.16 degrees.
module cfc_cordic import cfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic               r_neg;
    logic [3:0]         r_iter;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [25:0] r_z;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [25:0] at;
    logic signed [32:0] xr;
    logic signed [32:0] yr;
    logic signed [15:0] cos_c;
    logic signed [15:0] sin_c;

    function automatic logic signed [15:0] clamp_one(input logic signed [32:0] v);
        logic signed [15:0] res;
        if (v > 33'(DIR_ONE)) begin
            res = DIR_ONE;
        end else if (v < -33'(DIR_ONE)) begin
            res = -DIR_ONE;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    assign xs    = r_x >>> r_iter;
    assign ys    = r_y >>> r_iter;
    assign at    = 26'($signed({1'b0, atan_deg(r_iter)}));
    assign xr    = (r_x + 33'sd32768) >>> 16;
    assign yr    = (r_y + 33'sd32768) >>> 16;
    assign cos_c = clamp_one(xr);
    assign sin_c = clamp_one(yr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_neg  <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (!r_z[25]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'd15) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_cos  <= r_neg ? -cos_c : cos_c;
                r_sin  <= r_neg ? -sin_c : sin_c;
            end else if (i_req.start) begin
                // fold into the right half-plane, flip the signs at the end
                if (i_req.angle > QUARTER_ANG) begin
                    r_z   <= i_req.angle - HALF_ANG;
                    r_neg <= 1'b1;
                end else if (i_req.angle < -QUARTER_ANG) begin
                    r_z   <= i_req.angle + HALF_ANG;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= i_req.angle;
                    r_neg <= 1'b0;
                end
                r_x    <= CORDIC_X0;
                r_y    <= '0;
                r_iter <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.sin_v = r_sin;
    assign o_rsp.cos_v = r_cos;

endmodule

>>> rtl/cfc_divsqrt.sv
// Bit-serial unsigned divider and integer square root sharing one register set.
module cfc_divsqrt import cfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ds_req i_req,
    output t_ds_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_op;
    logic [4:0]  r_cnt;
    logic [31:0] r_num;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_den;
    logic [31:0] r_bit;

    logic [16:0] rem_sh;
    logic        div_fit;
    logic [16:0] rem_sub;
    logic [31:0] sq_t;
    logic        sq_fit;

    assign rem_sh  = {r_rem, r_num[31]};
    assign div_fit = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign sq_t    = r_quo + r_bit;
    assign sq_fit  = r_num >= sq_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_op == DS_DIV) begin
                    r_rem <= div_fit ? rem_sub[15:0] : rem_sh[15:0];
                    r_quo <= {r_quo[30:0], div_fit};
                    r_num <= {r_num[30:0], 1'b0};
                end else begin
                    if (sq_fit) begin
                        r_num <= r_num - sq_t;
                        r_quo <= (r_quo >> 1) + r_bit;
                    end else begin
                        r_quo <= r_quo >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_op   <= i_req.op;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_bit  <= 32'h4000_0000;
                r_cnt  <= (i_req.op == DS_SQRT) ? 5'd15 : 5'd31;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_quo;

endmodule

>>> rtl/euler_fly_camera_controller_top.sv
// Fly camera controller: sequencer, shared multiplier, camera state and channels.
//
//  channel  | dir | handshake           | carries
//  i_in     | in  | valid/ready         | mode, pointer, key, frame time
//  o_out    | out | valid/ready         | direction, position, yaw, pitch
//  i_cfg_*  | in  | write enable only   | sensitivity, speed, pitch limit
//
// Key and reset-pose items go from decode straight to the result; a pointer item
// runs two CORDIC passes and a 10-step heading wrap; a tick item runs the
// 32-step divider up to five times and two 16-step roots.
// One item at a time: i_in.ready is high only while the sequencer idles.
// The result register holds a finished item until o_out takes it.
// Reset is synchronous and restores the start pose and default registers.
module euler_fly_camera_controller_top import cfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    cfc_in_if.sink      i_in,
    cfc_out_if.source   o_out
);

    localparam logic [5:0] ST_IDLE = 6'd0,  ST_DECODE = 6'd1,  ST_MDX = 6'd2,
                           ST_MDY  = 6'd3,  ST_ELEV   = 6'd4,  ST_MOD = 6'd5,
                           ST_C1S  = 6'd6,  ST_C1W    = 6'd7,  ST_C2S = 6'd8,
                           ST_C2W  = 6'd9,  ST_MX     = 6'd10, ST_MZ  = 6'd11,
                           ST_MZW  = 6'd12, ST_T0     = 6'd13, ST_T1  = 6'd14,
                           ST_T2   = 6'd15, ST_TS     = 6'd16, ST_TW  = 6'd17,
                           ST_D0S  = 6'd18, ST_D0W    = 6'd19, ST_D2S = 6'd20,
                           ST_D2W  = 6'd21, ST_M      = 6'd22, ST_Q0  = 6'd23,
                           ST_Q1   = 6'd24, ST_Q2     = 6'd25, ST_Q3  = 6'd26,
                           ST_QS   = 6'd27, ST_QW     = 6'd28, ST_NS  = 6'd29,
                           ST_NW   = 6'd30, ST_P1     = 6'd31, ST_P2  = 6'd32,
                           ST_P3   = 6'd33, ST_DONE   = 6'd34;

    logic [5:0]         r_state;
    logic [15:0]        r_sens;
    logic [15:0]        r_speed;
    logic [6:0]         r_plim;

    logic signed [24:0] r_heading;
    logic signed [23:0] r_elev;
    logic signed [15:0] r_dir [3];
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_last_x;
    logic signed [15:0] r_last_y;
    logic               r_first;
    logic [3:0]         r_keys;

    logic [1:0]         r_mode;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic [1:0]         r_code;
    logic               r_pressed;
    logic [15:0]        r_dt;

    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic [35:0]        r_acc;
    logic [3:0]         r_cnt;
    logic signed [15:0] r_sp;
    logic signed [15:0] r_cp;
    logic signed [15:0] r_sy;
    logic signed [15:0] r_cy;
    logic [31:0]        r_sum;
    logic [15:0]        r_len;
    logic signed [15:0] r_r0;
    logic signed [15:0] r_r2;
    logic signed [15:0] r_n;
    logic signed [16:0] r_m [3];
    logic [1:0]         r_k;
    logic signed [50:0] r_prod;

    logic               r_ovalid;
    logic signed [15:0] r_o_dir [3];
    logic signed [31:0] r_o_pos [3];
    logic signed [24:0] r_o_yaw;
    logic signed [23:0] r_o_pitch;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] n_prod;
    logic signed [36:0] wrap_sum;
    logic [35:0]        mod_cmp;
    logic [35:0]        n_acc;
    logic [6:0]         plim_eff;
    logic signed [34:0] elev_sum;
    logic signed [34:0] elev_lim;
    logic signed [23:0] n_elev;
    logic signed [17:0] m_sum [3];
    logic signed [15:0] r_sel [3];
    logic [15:0]        abs_dx;
    logic [15:0]        abs_dz;
    logic [16:0]        abs_m;
    logic signed [50:0] dir_rnd;
    logic signed [50:0] pos_step;
    logic signed [51:0] pos_sum;
    logic signed [31:0] n_pos;
    logic signed [15:0] ds_q;

    t_cordic_req        cordic_req;
    t_cordic_rsp        cordic_rsp;
    t_ds_req            ds_req;
    t_ds_rsp            ds_rsp;

    cfc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    cfc_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .o_rsp   (ds_rsp)
    );

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MDX: begin
                mul_a = 33'(r_dx);
                mul_b = {2'b00, r_sens};
            end
            ST_MDY: begin
                mul_a = 33'(r_dy);
                mul_b = {2'b00, r_sens};
            end
            ST_MX: begin
                mul_a = 33'(r_cp);
                mul_b = 18'(r_cy);
            end
            ST_MZ: begin
                mul_a = 33'(r_cp);
                mul_b = 18'(r_sy);
            end
            ST_T0: begin
                mul_a = 33'(r_dir[0]);
                mul_b = 18'(r_dir[0]);
            end
            ST_T1: begin
                mul_a = 33'(r_dir[2]);
                mul_b = 18'(r_dir[2]);
            end
            ST_Q0: begin
                mul_a = 33'(r_m[0]);
                mul_b = 18'(r_m[0]);
            end
            ST_Q1: begin
                mul_a = 33'(r_m[1]);
                mul_b = 18'(r_m[1]);
            end
            ST_Q2: begin
                mul_a = 33'(r_m[2]);
                mul_b = 18'(r_m[2]);
            end
            ST_P1: begin
                mul_a = 33'(r_n);
                mul_b = {2'b00, r_speed};
            end
            ST_P2: begin
                mul_a = r_prod[32:0];
                mul_b = {2'b00, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // Heading wrap: bias to positive, then one restoring step a cycle
    assign wrap_sum = 37'(r_heading) + 37'(HALF_TURN) + 37'(r_prod)
                    + $signed({1'b0, WRAP_BIAS});
    assign mod_cmp  = FULL_TURN << r_cnt;
    assign n_acc    = (r_acc >= mod_cmp) ? (r_acc - mod_cmp) : r_acc;

    assign plim_eff = (r_plim > PITCH_MAX) ? PITCH_MAX : r_plim;
    assign elev_sum = 35'(r_elev) + 35'(r_prod);
    assign elev_lim = $signed({12'b0, plim_eff, 16'b0});

    always_comb begin
        if (elev_sum > elev_lim) begin
            n_elev = 24'(elev_lim);
        end else if (elev_sum < -elev_lim) begin
            n_elev = 24'(-elev_lim);
        end else begin
            n_elev = 24'(elev_sum);
        end
    end

    // Movement sum per axis from the held keys
    always_comb begin
        r_sel[0] = r_r0;
        r_sel[1] = '0;
        r_sel[2] = r_r2;
        for (int k = 0; k < 3; k++) begin
            m_sum[k] = '0;
            if (r_keys[KEY_FWD]) begin
                m_sum[k] = m_sum[k] + 18'(r_dir[k]);
            end
            if (r_keys[KEY_BACK]) begin
                m_sum[k] = m_sum[k] - 18'(r_dir[k]);
            end
            if (r_keys[KEY_LEFT]) begin
                m_sum[k] = m_sum[k] - 18'(r_sel[k]);
            end
            if (r_keys[KEY_RIGHT]) begin
                m_sum[k] = m_sum[k] + 18'(r_sel[k]);
            end
        end
    end

    assign abs_dx = r_dir[0][15] ? 16'(-r_dir[0]) : 16'(r_dir[0]);
    assign abs_dz = r_dir[2][15] ? 16'(-r_dir[2]) : 16'(r_dir[2]);
    assign abs_m  = r_m[r_k][16] ? 17'(-r_m[r_k]) : 17'(r_m[r_k]);

    assign dir_rnd  = (r_prod + 51'sd8192) >>> DIR_FB;
    assign pos_step = (r_prod + 51'sd2097152) >>> 22;
    assign pos_sum  = 52'(r_pos[r_k]) + 52'(pos_step);

    always_comb begin
        if (pos_sum > 52'sd2147483647) begin
            n_pos = 32'sh7FFF_FFFF;
        end else if (pos_sum < -52'sd2147483648) begin
            n_pos = 32'sh8000_0000;
        end else begin
            n_pos = 32'(pos_sum);
        end
    end

    assign ds_q = $signed(ds_rsp.res[15:0]);

    always_comb begin
        cordic_req.start = (r_state == ST_C1S) || (r_state == ST_C2S);
        cordic_req.angle = (r_state == ST_C1S) ? 26'(r_elev) : 26'(r_heading);
    end

    always_comb begin
        ds_req.start = 1'b0;
        ds_req.op    = DS_DIV;
        ds_req.num   = '0;
        ds_req.den   = r_len;
        case (r_state)
            ST_TS, ST_QS: begin
                ds_req.start = 1'b1;
                ds_req.op    = DS_SQRT;
                ds_req.num   = r_sum;
            end
            ST_D0S: begin
                ds_req.start = 1'b1;
                ds_req.num   = ({16'b0, abs_dz} << DIR_FB) + {17'b0, r_len[15:1]};
            end
            ST_D2S: begin
                ds_req.start = 1'b1;
                ds_req.num   = ({16'b0, abs_dx} << DIR_FB) + {17'b0, r_len[15:1]};
            end
            ST_NS: begin
                ds_req.start = 1'b1;
                ds_req.num   = ({15'b0, abs_m} << DIR_FB) + {17'b0, r_len[15:1]};
            end
            default: begin
                ds_req.start = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= 16'd3277;
            r_speed <= 16'd2560;
            r_plim  <= PITCH_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENS:  r_sens  <= i_cfg_data;
                CFG_SPEED: r_speed <= i_cfg_data;
                CFG_PLIM:  r_plim  <= i_cfg_data[6:0];
                default:   r_sens  <= r_sens;
            endcase
        end
    end

    // Sequencer and camera state
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_heading <= HEADING_RST;
            r_elev    <= '0;
            r_dir[0]  <= '0;
            r_dir[1]  <= '0;
            r_dir[2]  <= -DIR_ONE;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_pos[2]  <= POS_Z_RST;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_first   <= 1'b1;
            r_keys    <= '0;
            r_cnt     <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // the finishing state loads the result register itself
            if (o_out.ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_mode    <= i_in.mode;
                        r_px      <= i_in.pointer_x;
                        r_py      <= i_in.pointer_y;
                        r_code    <= i_in.key_code;
                        r_pressed <= i_in.key_pressed;
                        r_dt      <= i_in.frame_time;
                        r_state   <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    case (r_mode)
                        MODE_POINTER: begin
                            r_last_x <= r_px;
                            r_last_y <= r_py;
                            if (r_first) begin
                                r_first <= 1'b0;
                                r_state <= ST_DONE;
                            end else begin
                                r_dx    <= 17'(r_px) - 17'(r_last_x);
                                r_dy    <= 17'(r_last_y) - 17'(r_py);
                                r_state <= ST_MDX;
                            end
                        end
                        MODE_KEY: begin
                            r_keys[r_code] <= r_pressed;
                            r_state        <= ST_DONE;
                        end
                        MODE_TICK: begin
                            r_state <= ST_T0;
                        end
                        MODE_RESET: begin
                            r_heading <= HEADING_RST;
                            r_elev    <= '0;
                            r_dir[0]  <= '0;
                            r_dir[1]  <= '0;
                            r_dir[2]  <= -DIR_ONE;
                            r_pos[0]  <= '0;
                            r_pos[1]  <= '0;
                            r_pos[2]  <= POS_Z_RST;
                            r_state   <= ST_DONE;
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_MDX: r_state <= ST_MDY;
                ST_MDY: begin
                    r_acc   <= wrap_sum[35:0];
                    r_cnt   <= 4'd9;
                    r_state <= ST_ELEV;
                end
                ST_ELEV: begin
                    r_elev  <= n_elev;
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    r_acc <= n_acc;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_heading <= 25'(n_acc) - HALF_TURN;
                        r_state   <= ST_C1S;
                    end
                end
                ST_C1S: r_state <= ST_C1W;
                ST_C1W: begin
                    if (cordic_rsp.done) begin
                        r_sp    <= cordic_rsp.sin_v;
                        r_cp    <= cordic_rsp.cos_v;
                        r_state <= ST_C2S;
                    end
                end
                ST_C2S: r_state <= ST_C2W;
                ST_C2W: begin
                    if (cordic_rsp.done) begin
                        r_sy    <= cordic_rsp.sin_v;
                        r_cy    <= cordic_rsp.cos_v;
                        r_state <= ST_MX;
                    end
                end
                ST_MX: r_state <= ST_MZ;
                ST_MZ: begin
                    r_dir[0] <= dir_rnd[15:0];
                    r_state  <= ST_MZW;
                end
                ST_MZW: begin
                    r_dir[2] <= dir_rnd[15:0];
                    r_dir[1] <= r_sp;
                    r_state  <= ST_DONE;
                end
                ST_T0: r_state <= ST_T1;
                ST_T1: begin
                    r_sum   <= r_prod[31:0];
                    r_state <= ST_T2;
                end
                ST_T2: begin
                    r_sum   <= r_sum + r_prod[31:0];
                    r_state <= ST_TS;
                end
                ST_TS: r_state <= ST_TW;
                ST_TW: begin
                    if (ds_rsp.done) begin
                        r_len <= ds_rsp.res[15:0];
                        if (ds_rsp.res[15:0] == 16'd0) begin
                            // no horizontal heading: no right vector
                            r_r0    <= '0;
                            r_r2    <= '0;
                            r_state <= ST_M;
                        end else begin
                            r_state <= ST_D0S;
                        end
                    end
                end
                ST_D0S: r_state <= ST_D0W;
                ST_D0W: begin
                    if (ds_rsp.done) begin
                        r_r0    <= (r_dir[2] > 16'sd0) ? -ds_q : ds_q;
                        r_state <= ST_D2S;
                    end
                end
                ST_D2S: r_state <= ST_D2W;
                ST_D2W: begin
                    if (ds_rsp.done) begin
                        r_r2    <= r_dir[0][15] ? -ds_q : ds_q;
                        r_state <= ST_M;
                    end
                end
                ST_M: begin
                    r_m[0]  <= 17'(m_sum[0]);
                    r_m[1]  <= 17'(m_sum[1]);
                    r_m[2]  <= 17'(m_sum[2]);
                    r_state <= ST_Q0;
                end
                ST_Q0: r_state <= ST_Q1;
                ST_Q1: begin
                    r_sum   <= r_prod[31:0];
                    r_state <= ST_Q2;
                end
                ST_Q2: begin
                    r_sum   <= r_sum + r_prod[31:0];
                    r_state <= ST_Q3;
                end
                ST_Q3: begin
                    r_sum   <= r_sum + r_prod[31:0];
                    r_state <= ST_QS;
                end
                ST_QS: r_state <= ST_QW;
                ST_QW: begin
                    if (ds_rsp.done) begin
                        r_len <= ds_rsp.res[15:0];
                        r_k   <= '0;
                        // zero movement sum: hold the position
                        r_state <= (ds_rsp.res[15:0] == 16'd0) ? ST_DONE : ST_NS;
                    end
                end
                ST_NS: r_state <= ST_NW;
                ST_NW: begin
                    if (ds_rsp.done) begin
                        r_n     <= r_m[r_k][16] ? -ds_q : ds_q;
                        r_state <= ST_P1;
                    end
                end
                ST_P1: r_state <= ST_P2;
                ST_P2: r_state <= ST_P3;
                ST_P3: begin
                    r_pos[r_k] <= n_pos;
                    if (r_k == 2'd2) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_NS;
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_dir[0] <= r_dir[0];
                        r_o_dir[1] <= r_dir[1];
                        r_o_dir[2] <= r_dir[2];
                        r_o_pos[0] <= r_pos[0];
                        r_o_pos[1] <= r_pos[1];
                        r_o_pos[2] <= r_pos[2];
                        r_o_yaw    <= r_heading;
                        r_o_pitch  <= r_elev;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.dir_x       = r_o_dir[0];
    assign o_out.dir_y       = r_o_dir[1];
    assign o_out.dir_z       = r_o_dir[2];
    assign o_out.pos_x       = r_o_pos[0];
    assign o_out.pos_y       = r_o_pos[1];
    assign o_out.pos_z       = r_o_pos[2];
    assign o_out.yaw_angle   = r_o_yaw;
    assign o_out.pitch_angle = r_o_pitch;

    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heading >= -HALF_TURN) && (r_heading < HALF_TURN))
        else $error("heading outside one turn");

    a_pitch_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elev <= PITCH_BOUND) && (r_elev >= -PITCH_BOUND))
        else $error("pitch beyond the largest limit");

    a_cordic_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_rsp.done |-> (r_state == ST_C1W) || (r_state == ST_C2W))
        else $error("CORDIC result with no request waiting");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while the previous one is in work");

endmodule

>>> sim/euler_fly_camera_controller_top_tb.sv
// Self-checking testbench of the fly camera controller: directed table, then random phases.
`timescale 1ns / 1ps

module euler_fly_camera_controller_top_tb import cfc_pkg::*; ();

    typedef struct {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [24:0] yaw;
        logic signed [23:0] pitch;
    } t_cam_pose;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [1:0]         key;
        logic               pressed;
        logic [15:0]        dt;
    } t_cam_event;

    typedef struct {
        t_cam_event ev;
        bit         known;
    } t_table_row;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint ATAN_TAB [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                         58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                         229, 115};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    cfc_in_if  in_ch();
    cfc_out_if out_ch();

    euler_fly_camera_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // camera model state
    longint sens, speed, plim;
    longint yaw_q, pitch_q, last_px, last_py;
    longint dir_v [3];
    longint pos_v [3];
    bit     pointer_armed;
    logic [3:0] keys_down;

    t_cam_pose pose_q [$];
    int        errors;
    int        idle_cycles;
    bit        no_gaps;
    t_cam_pose home_pose;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint div_near(longint n, longint d);
        if (d <= 0) return 0;
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void sin_cos_q14(input longint a, output longint s, output longint c);
        longint x, y, z, xs, ys;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (a > 90 * 65536) begin
            a -= 180 * 65536;
            flip = 1;
        end else if (a < -90 * 65536) begin
            a += 180 * 65536;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        x = rnd_shift(x, 16);
        y = rnd_shift(y, 16);
        if (x > 16384) x = 16384;
        if (x < -16384) x = -16384;
        if (y > 16384) y = 16384;
        if (y < -16384) y = -16384;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void home_camera();
        yaw_q   = -90 * 65536;
        pitch_q = 0;
        dir_v   = '{0, 0, -16384};
        pos_v   = '{0, 0, 3 * 65536};
    endfunction

    function automatic void turn_camera(longint px, longint py);
        longint dx, dy, t, lim, sp, cp, sy, cy;
        if (pointer_armed) begin
            last_px = px;
            last_py = py;
            pointer_armed = 0;
            return;
        end
        dx = (px - last_px) * sens;
        dy = (last_py - py) * sens;
        last_px = px;
        last_py = py;
        t = (yaw_q + dx + 180 * 65536) % (360 * 65536);
        if (t < 0) t += 360 * 65536;
        yaw_q = t - 180 * 65536;
        lim = (plim > 89 ? 89 : plim) * 65536;
        pitch_q += dy;
        if (pitch_q > lim) pitch_q = lim;
        if (pitch_q < -lim) pitch_q = -lim;
        sin_cos_q14(pitch_q, sp, cp);
        sin_cos_q14(yaw_q, sy, cy);
        dir_v[0] = rnd_shift(cp * cy, 14);
        dir_v[1] = sp;
        dir_v[2] = rnd_shift(cp * sy, 14);
    endfunction

    function automatic void move_camera(longint dt);
        longint rv [3];
        longint mv [3];
        longint len, n, d;
        rv = '{0, 0, 0};
        mv = '{0, 0, 0};
        len = sqrt_floor(dir_v[0] * dir_v[0] + dir_v[2] * dir_v[2]);
        if (len != 0) begin
            rv[0] = div_near(-dir_v[2] * 16384, len);
            rv[2] = div_near(dir_v[0] * 16384, len);
        end
        for (int k = 0; k < 3; k++) begin
            if (keys_down[KEY_FWD])   mv[k] += dir_v[k];
            if (keys_down[KEY_BACK])  mv[k] -= dir_v[k];
            if (keys_down[KEY_LEFT])  mv[k] -= rv[k];
            if (keys_down[KEY_RIGHT]) mv[k] += rv[k];
        end
        len = sqrt_floor(mv[0] * mv[0] + mv[1] * mv[1] + mv[2] * mv[2]);
        if (len == 0) return;
        for (int k = 0; k < 3; k++) begin
            n = div_near(mv[k] * 16384, len);
            d = rnd_shift(n * speed * dt, 22);
            pos_v[k] += d;
            if (pos_v[k] > 64'sd2147483647) pos_v[k] = 64'sd2147483647;
            if (pos_v[k] < -64'sd2147483648) pos_v[k] = -64'sd2147483648;
        end
    endfunction

    function automatic t_cam_pose apply_event(t_cam_event ev);
        t_cam_pose p;
        case (ev.mode)
            MODE_POINTER: turn_camera(ev.px, ev.py);
            MODE_KEY:     keys_down[ev.key] = ev.pressed;
            MODE_TICK:    move_camera(ev.dt);
            default:      home_camera();
        endcase
        p.dir_x = 16'(dir_v[0]);
        p.dir_y = 16'(dir_v[1]);
        p.dir_z = 16'(dir_v[2]);
        p.pos_x = 32'(pos_v[0]);
        p.pos_y = 32'(pos_v[1]);
        p.pos_z = 32'(pos_v[2]);
        p.yaw   = 25'(yaw_q);
        p.pitch = 24'(pitch_q);
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SENS:  sens  = val;
            CFG_SPEED: speed = val;
            default:   plim  = val[6:0];
        endcase
    endtask

    task automatic send_event(t_cam_event ev, bit known);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.mode        = ev.mode;
        in_ch.pointer_x   = ev.px;
        in_ch.pointer_y   = ev.py;
        in_ch.key_code    = ev.key;
        in_ch.key_pressed = ev.pressed;
        in_ch.frame_time  = ev.dt;
        do @(posedge i_clk); while (!in_ch.ready);
        if (known) begin
            void'(apply_event(ev));
            pose_q.push_back(home_pose);
        end else begin
            pose_q.push_back(apply_event(ev));
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic t_cam_event mk(logic [1:0] m, int px, int py, logic [1:0] k,
                                      logic pr, int dt);
        t_cam_event e;
        e.mode = m; e.px = 16'(px); e.py = 16'(py); e.key = k; e.pressed = pr;
        e.dt = 16'(dt);
        return e;
    endfunction

    function automatic t_cam_event random_event(inout longint cx, inout longint cy);
        t_cam_event e;
        int r;
        e = mk(MODE_TICK, $urandom, $urandom, 2'($urandom), 1'($urandom), $urandom);
        r = $urandom_range(0, 99);
        if (r < 35) begin
            e.mode = MODE_POINTER;
            if ($urandom_range(0, 4) != 0) begin
                cx += $signed($urandom_range(0, 800)) - 400;
                cy += $signed($urandom_range(0, 800)) - 400;
                e.px = 16'(cx);
                e.py = 16'(cy);
            end
            cx = e.px;
            cy = e.py;
        end else if (r < 60) begin
            e.mode = MODE_KEY;
            e.pressed = $urandom_range(0, 99) < 60;
        end else if (r < 97) begin
            e.mode = MODE_TICK;
            if ($urandom_range(0, 3) != 0) e.dt = 16'($urandom_range(0, 4000));
        end else begin
            e.mode = MODE_RESET;
        end
        return e;
    endfunction

    // receiver stalls
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready = 1'b0;
                hold--;
            end else begin
                out_ch.ready = 1'b1;
                hold = pick_gap();
            end
        end
    end

    // compare each result with the oldest outstanding pose
    always @(posedge i_clk) begin
        t_cam_pose w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: result item with nothing outstanding", $realtime);
                errors++;
            end else begin
                w = pose_q.pop_front();
                if (out_ch.dir_x !== w.dir_x) report_mismatch("dir_x", out_ch.dir_x, w.dir_x);
                if (out_ch.dir_y !== w.dir_y) report_mismatch("dir_y", out_ch.dir_y, w.dir_y);
                if (out_ch.dir_z !== w.dir_z) report_mismatch("dir_z", out_ch.dir_z, w.dir_z);
                if (out_ch.pos_x !== w.pos_x) report_mismatch("pos_x", out_ch.pos_x, w.pos_x);
                if (out_ch.pos_y !== w.pos_y) report_mismatch("pos_y", out_ch.pos_y, w.pos_y);
                if (out_ch.pos_z !== w.pos_z) report_mismatch("pos_z", out_ch.pos_z, w.pos_z);
                if (out_ch.yaw_angle !== w.yaw)
                    report_mismatch("yaw_angle", out_ch.yaw_angle, w.yaw);
                if (out_ch.pitch_angle !== w.pitch)
                    report_mismatch("pitch_angle", out_ch.pitch_angle, w.pitch);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[euler_fly_camera_controller_top] ERROR");
            $finish;
        end
    end

    initial begin
        t_table_row rows [$];
        longint cx, cy;
        int plan [6][3] = '{'{3277, 2560, 89}, '{0, 0, 0}, '{65535, 65535, 127},
                           '{1, 1, 45}, '{-1, -1, -1}, '{65535, 65535, 100}};
        errors = 0;
        idle_cycles = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SENS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_KEY;
        in_ch.pointer_x = '0;
        in_ch.pointer_y = '0;
        in_ch.key_code = KEY_FWD;
        in_ch.key_pressed = 1'b0;
        in_ch.frame_time = '0;
        home_pose = '{16'sd0, 16'sd0, -16'sd16384, 32'sd0, 32'sd0, 32'sd196608,
                      -25'sd5898240, 24'sd0};
        sens = 3277; speed = 2560; plim = 89;
        home_camera();
        last_px = 0; last_py = 0;
        pointer_armed = 1;
        keys_down = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // known rows: start pose still in place, or just restored
        rows = '{
            '{mk(MODE_KEY, 0, 0, KEY_FWD, 1, 0), 1},
            '{mk(MODE_POINTER, 100, -200, KEY_FWD, 0, 0), 1},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 16'hFFFF), 0},
            '{mk(MODE_POINTER, 32767, -32768, KEY_FWD, 0, 0), 0},
            '{mk(MODE_POINTER, -32768, 32767, KEY_FWD, 0, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 16'hFFFF), 0},
            '{mk(MODE_KEY, 0, 0, KEY_LEFT, 1, 0), 0},
            '{mk(MODE_KEY, 0, 0, KEY_FWD, 0, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 30000), 0},
            '{mk(MODE_KEY, 0, 0, KEY_RIGHT, 1, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 30000), 0},
            '{mk(MODE_KEY, 0, 0, KEY_FWD, 1, 0), 0},
            '{mk(MODE_KEY, 0, 0, KEY_BACK, 1, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 16'hFFFF), 0},
            '{mk(MODE_RESET, 0, 0, KEY_FWD, 0, 0), 1},
            '{mk(MODE_KEY, 0, 0, KEY_BACK, 0, 0), 1},
            '{mk(MODE_KEY, 0, 0, KEY_LEFT, 0, 0), 1},
            '{mk(MODE_KEY, 0, 0, KEY_RIGHT, 0, 0), 1},
            '{mk(MODE_POINTER, 0, 0, KEY_FWD, 0, 0), 0},
            '{mk(MODE_POINTER, 5, 0, KEY_FWD, 0, 0), 0},
            '{mk(MODE_TICK, 0, 0, KEY_FWD, 0, 16'hFFFF), 0},
            '{mk(MODE_RESET, 0, 0, KEY_FWD, 0, 0), 1}
        };
        foreach (rows[i]) send_event(rows[i].ev, rows[i].known);
        drain();

        cx = 0;
        cy = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_SENS,
                      16'(plan[ph][0] < 0 ? $urandom_range(0, 8000) : plan[ph][0]));
            write_reg(CFG_SPEED, 16'(plan[ph][1] < 0 ? $urandom : plan[ph][1]));
            write_reg(CFG_PLIM,
                      16'(plan[ph][2] < 0 ? $urandom_range(0, 127) : plan[ph][2]));
            no_gaps = (ph == 2);
            for (int n = 0; n < 305; n++) send_event(random_event(cx, cy), 0);
            drain();
        end
        no_gaps = 0;

        if (errors == 0)
            $display("[euler_fly_camera_controller_top] OK");
        else
            $display("[euler_fly_camera_controller_top] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cfc_pkg.sv
rtl/cfc_if.sv
rtl/cfc_cordic.sv
rtl/cfc_divsqrt.sv
rtl/euler_fly_camera_controller_top.sv
sim/euler_fly_camera_controller_top_tb.sv
